// ----- rtl/sae_pkg.sv -----
// Shared types and constants for the stack arithmetic engine.
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

  localparam int OPCODE_W    = 4;
  localparam int OPERAND_W   = 32;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 9;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_TOP   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_SUB   = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_MUL   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_DIV   = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_MOD   = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_EMPTY = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_SIZE  = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_RDV,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_NEGA,
    S_NEGB,
    S_MULT,
    S_DIVS,
    S_FIX,
    S_PUSH,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/stack_arithmetic_engine_unit.sv -----
// Top level of the stack arithmetic engine: sequencer, stack memory and shared adder.
// Multiply, divide and modulo make one pass per data bit through the shared adder; a zero
// divisor skips the divide. One instruction is in work at a time; the next word can be
// taken in the cycle after the result is registered, later while a result word waits on
// out_tready.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result word.
`timescale 1ns / 1ps
`default_nettype none

module stack_arithmetic_engine_unit #(
  parameter int STACK_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [3:0] opcode, [35:4] operand, [39:36] zero
  input  wire logic [sae_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] value, [33:32] status, [42:34] depth_count, [43] is_empty, [47:44] zero
  output logic [sae_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  import sae_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int ITW = $clog2(DW + 1);
  localparam int XW  = (DW > OPERAND_W) ? DW : OPERAND_W;
  localparam int KW  = (CW > DEPTH_W) ? CW : DEPTH_W;

  // Stack memory, one write and one registered read port.
  logic [DW-1:0] mem [STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] rd_data_r;

  state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [DW-1:0]       opnd_r, opnd_nxt;
  logic [DW-1:0]       a_r, a_nxt;
  logic [DW-1:0]       b_r, b_nxt;
  logic [DW-1:0]       acc_r, acc_nxt;
  logic [DW-1:0]       value_r, value_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                a_vld_r, a_vld_nxt;
  logic                b_vld_r, b_vld_nxt;
  logic                sign_a_r, sign_a_nxt;
  logic                sign_b_r, sign_b_nxt;
  logic [ITW-1:0]      iter_r, iter_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic [XW-1:0] opnd_ext;
  logic [XW-1:0] value_ext;
  logic [KW-1:0] count_ext;
  logic [CW-1:0] count_dec;
  logic          out_free;
  logic          iter_last;
  logic          fix_neg;
  logic [DW-1:0] fix_src;

  // Shared adder/subtractor, one bit wider than the data for the divide borrow.
  logic [DW:0] add_x, add_y, add_sum;
  logic        add_sub;

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (DW + 1)'(add_sub);

  assign opnd_ext  = XW'($signed(in_tdata[OPCODE_W +: OPERAND_W]));
  assign value_ext = XW'(value_r);
  assign count_ext = KW'(count_r);
  assign count_dec = count_r - CW'(1);
  assign out_free  = !out_tvalid_r || out_tready;
  assign iter_last = (iter_r == ITW'(1));
  assign fix_neg   = (op_r == OP_DIV) ? (sign_a_r ^ sign_b_r) : sign_a_r;
  assign fix_src   = (op_r == OP_DIV) ? a_r : acc_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_empty_r, out_depth_r, out_status_r, out_value_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (op_r)
          OP_POP, OP_TOP: begin
            state_nxt = (count_r == '0) ? S_DONE : S_RDV;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: state_nxt = S_RDA;
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDV: state_nxt = S_DONE;
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (op_r)
          OP_MUL:         state_nxt = S_MULT;
          OP_DIV, OP_MOD: state_nxt = (b_r == '0) ? S_DONE : S_NEGA;
          default:        state_nxt = S_PUSH;
        endcase
      end
      S_NEGA: state_nxt = S_NEGB;
      S_NEGB: state_nxt = S_DIVS;
      S_MULT: begin
        if (iter_last) state_nxt = S_PUSH;
      end
      S_DIVS: begin
        if (iter_last) state_nxt = S_FIX;
      end
      S_FIX:  state_nxt = S_PUSH;
      S_PUSH: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_nxt      = count_r;
    op_nxt         = op_r;
    opnd_nxt       = opnd_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    a_vld_nxt      = a_vld_r;
    b_vld_nxt      = b_vld_r;
    sign_a_nxt     = sign_a_r;
    sign_b_nxt     = sign_b_r;
    iter_nxt       = iter_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = acc_r;
    mem_raddr      = count_dec[AW-1:0];
    add_x          = {1'b0, a_r};
    add_y          = {1'b0, b_r};
    add_sub        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[OPCODE_W-1:0];
          opnd_nxt   = opnd_ext[DW-1:0];
          value_nxt  = '0;
          status_nxt = ST_OK;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_PUSH: begin
            if (count_r == CW'(STACK_DEPTH)) begin
              status_nxt = ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = opnd_r;
              count_nxt = count_r + CW'(1);
              value_nxt = opnd_r;
            end
          end
          OP_POP: begin
            if (count_r == '0) status_nxt = ST_UNDER;
            else count_nxt = count_dec;
          end
          OP_TOP: begin
            if (count_r == '0) status_nxt = ST_UNDER;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            a_vld_nxt = (count_r != '0);
            b_vld_nxt = (count_r > CW'(1));
            if (count_r < CW'(2)) status_nxt = ST_UNDER;
            if (count_r != '0) count_nxt = count_dec;
          end
          default: ;
        endcase
      end
      S_RDV: value_nxt = rd_data_r;
      S_RDA: begin
        a_nxt = a_vld_r ? rd_data_r : '0;
        if (count_r != '0) count_nxt = count_dec;
      end
      S_RDB: b_nxt = b_vld_r ? rd_data_r : '0;
      S_EXEC: begin
        add_sub    = (op_r == OP_SUB);
        acc_nxt    = (op_r == OP_MUL) ? '0 : add_sum[DW-1:0];
        iter_nxt   = ITW'(DW);
        sign_a_nxt = a_r[DW-1];
        sign_b_nxt = b_r[DW-1];
        if (((op_r == OP_DIV) || (op_r == OP_MOD)) && (b_r == '0) && (status_r == ST_OK)) begin
          status_nxt = ST_DIVZ;
        end
      end
      S_NEGA: begin
        add_x   = '0;
        add_y   = {1'b0, a_r};
        add_sub = 1'b1;
        if (sign_a_r) a_nxt = add_sum[DW-1:0];
        acc_nxt = '0;
      end
      S_NEGB: begin
        add_x   = '0;
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
        if (sign_b_r) b_nxt = add_sum[DW-1:0];
      end
      S_MULT: begin
        // Multiplier bits are taken from the top, so the product builds by shift and add.
        add_x    = {1'b0, acc_r[DW-2:0], 1'b0};
        add_y    = b_r[DW-1] ? {1'b0, a_r} : '0;
        acc_nxt  = add_sum[DW-1:0];
        b_nxt    = {b_r[DW-2:0], 1'b0};
        iter_nxt = iter_r - ITW'(1);
      end
      S_DIVS: begin
        // Restoring divide: a_r shifts the dividend out and the quotient in.
        add_x    = {acc_r, a_r[DW-1]};
        add_y    = {1'b0, b_r};
        add_sub  = 1'b1;
        iter_nxt = iter_r - ITW'(1);
        if (!add_sum[DW]) begin
          acc_nxt = add_sum[DW-1:0];
          a_nxt   = {a_r[DW-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[DW-2:0], a_r[DW-1]};
          a_nxt   = {a_r[DW-2:0], 1'b0};
        end
      end
      S_FIX: begin
        add_x   = '0;
        add_y   = {1'b0, fix_src};
        add_sub = 1'b1;
        acc_nxt = fix_neg ? add_sum[DW-1:0] : fix_src;
      end
      S_PUSH: begin
        // The operand pops (two, or fewer on underflow) came first, so there is always room for the result.
        mem_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        value_nxt = acc_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = value_ext[VALUE_W-1:0];
          out_status_nxt = status_r;
          out_depth_nxt  = count_ext[DEPTH_W-1:0];
          out_empty_nxt  = (count_r == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    opnd_r       <= opnd_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    a_vld_r      <= a_vld_nxt;
    b_vld_r      <= b_vld_nxt;
    sign_a_r     <= sign_a_nxt;
    sign_b_r     <= sign_b_nxt;
    iter_r       <= iter_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("stack count moved by more than one");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the done state");

endmodule

`default_nettype wire
